[rtl/core/vpd_pkg.sv]
// Shared widths and constants for the vapour pressure deficit pipeline.
// Used by vpd_svp and vapour_pressure_deficit; depends on nothing.
package vpd_pkg;

    localparam int TEMP_IN_W    = 14;
    localparam int RH_W         = 10;
    localparam int OFFS_W       = 11;
    localparam int TEMP_W       = 15;
    localparam int MAG_W        = 24;
    localparam int DEN_W        = 22;
    localparam int FRAC_W       = 24;
    localparam int XQ_W         = 28;
    localparam int YP_W         = 53;
    localparam int YM_W         = 29;
    localparam int EXP_W        = 7;
    localparam int ZP_W         = 48;
    localparam int TERM_W       = 31;
    localparam int TV_W         = 30;
    localparam int AP_W         = 55;
    localparam int RCP_SH       = 34;
    localparam int RCP_W        = 35;
    localparam int TQ_W         = 65;
    localparam int TAYLOR_TERMS = 12;
    localparam int SUM_W        = 31;
    localparam int SP_W         = 44;
    localparam int SVP_W        = 36;
    localparam int SH_W         = 5;
    localparam int ACT_W        = 36;
    localparam int ACT_P_W      = 46;
    localparam int ACT_X_SH     = 3;
    localparam int ACT_X_W      = 43;
    localparam int ACT_LO_W     = 22;
    localparam int ACT_RCP_W    = 44;
    localparam int ACT_PPL_W    = 44;
    localparam int ACT_PPH_W    = 43;
    localparam int ACT_MID_W    = 45;
    localparam int ACT_TOT_W    = 87;
    localparam int ACT_RCP_SH   = 50;
    localparam int ACT_LAT      = 4;
    localparam int DEF_PRE_W    = 21;
    localparam int DEF_PRE_SH   = 16;
    localparam int DEF_SUM_W    = 37;
    localparam int DEF_P_W      = 43;
    localparam int DEF_SH       = 25;
    localparam int DEF_Q_W      = 18;
    localparam int DEF_W        = 17;

    localparam int SVP_LAT      = 1 + XQ_W + 4 + 2 * TAYLOR_TERMS + 3;
    localparam int VLD_LEN      = 1 + SVP_LAT + ACT_LAT + 3;

    localparam logic [10:0]          MAGNUS_B      = 11'd1727;
    localparam logic [TEMP_W-1:0]    MAGNUS_C      = 15'd23730;
    localparam logic [6:0]           MAGNUS_SCALE  = 7'd100;
    localparam logic [24:0]          LOG2E_Q24     = 25'd24204406;
    localparam logic [FRAC_W-1:0]    LN2_Q24       = 24'd11629080;
    localparam logic [FRAC_W-1:0]    HALF_Q24      = 24'd8388608;
    localparam logic [TERM_W-1:0]    TERM_ONE      = 31'd1073741824;
    localparam logic [12:0]          SVP0_DPA      = 13'd6108;
    localparam logic [EXP_W-1:0]     SVP_EXP_BIAS  = 7'd14;
    localparam logic [ACT_RCP_W-1:0] ACT_RCP       = 44'd9007199254741;
    localparam logic [DEF_SUM_W-1:0] ROUND_HALF_PA = 37'd327680;
    localparam logic [21:0]          RECIP10       = 22'd3355444;
    localparam logic [DEF_Q_W-1:0]   DEFICIT_MAX   = 18'd131071;

endpackage

[rtl/core/vpd_svp.sv]
// Pipelined Magnus saturation pressure: divider, base-2 split, Taylor exp, scale.
// Depends on vpd_pkg; instantiated twice by vapour_pressure_deficit.
module vpd_svp import vpd_pkg::*; (
    input  logic              aclk,
    input  logic              adv,
    input  logic [TEMP_W-1:0] temp,
    output logic [SVP_W-1:0]  svp
);

    logic [TEMP_W-1:0] tabs;
    logic [TEMP_W:0]   tbias;
    logic [MAG_W-1:0]  mag_next;
    logic [DEN_W-1:0]  den_next;

    logic [DEN_W-1:0] drem_reg [0:XQ_W];
    logic [XQ_W-1:0]  dlow_reg [0:XQ_W];
    logic [DEN_W-1:0] dden_reg [0:XQ_W];
    logic             dneg_reg [0:XQ_W];

    logic [YP_W-1:0]   ymul_reg;
    logic              yneg_reg;
    logic [YP_W-1:0]   ysum;
    logic [YM_W-1:0]   ym;
    logic [FRAC_W-1:0] yml;
    logic [EXP_W-1:0]  yhi;
    logic [EXP_W-1:0]  n_next;
    logic [FRAC_W-1:0] f_next;
    logic [EXP_W-1:0]  n_reg;
    logic [FRAC_W-1:0] f_reg;
    logic [ZP_W-1:0]   zmul_reg;
    logic [EXP_W-1:0]  zn_reg;
    logic [ZP_W-1:0]   zsum;

    logic [TERM_W-1:0] term_reg [0:TAYLOR_TERMS];
    logic [SUM_W-1:0]  tsum_reg [0:TAYLOR_TERMS];
    logic [FRAC_W-1:0] tz_reg   [0:TAYLOR_TERMS];
    logic [EXP_W-1:0]  tn_reg   [0:TAYLOR_TERMS];
    logic [AP_W-1:0]   amul_reg [0:TAYLOR_TERMS-1];
    logic [SUM_W-1:0]  asum_reg [0:TAYLOR_TERMS-1];
    logic [FRAC_W-1:0] az_reg   [0:TAYLOR_TERMS-1];
    logic [EXP_W-1:0]  an_reg   [0:TAYLOR_TERMS-1];

    logic [SUM_W-1:0] sumf_reg;
    logic [EXP_W-1:0] sn1_reg;
    logic [SP_W-1:0]  s_reg;
    logic [EXP_W-1:0] sn2_reg;
    logic [EXP_W-1:0] shfull;
    logic [SVP_W-1:0] svp_reg;

    always_comb begin
        tabs     = temp[TEMP_W-1] ? (TEMP_W'(0) - temp) : temp;
        tbias    = {temp[TEMP_W-1], temp} + {1'b0, MAGNUS_C};
        mag_next = MAG_W'(tabs) * MAG_W'(MAGNUS_B);
        den_next = DEN_W'(tbias) * DEN_W'(MAGNUS_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            drem_reg[0] <= DEN_W'(mag_next[MAG_W-1:XQ_W-FRAC_W]);
            dlow_reg[0] <= {mag_next[XQ_W-FRAC_W-1:0], FRAC_W'(den_next[DEN_W-1:1])};
            dden_reg[0] <= den_next;
            dneg_reg[0] <= temp[TEMP_W-1];
        end
    end

    for (genvar i = 0; i < XQ_W; i++) begin : g_div
        logic [DEN_W:0] sh;
        logic [DEN_W:0] dif;
        logic           ge;
        always_comb begin
            sh  = {drem_reg[i], dlow_reg[i][XQ_W-1]};
            dif = sh - {1'b0, dden_reg[i]};
            ge  = sh >= {1'b0, dden_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                drem_reg[i+1] <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
                dlow_reg[i+1] <= {dlow_reg[i][XQ_W-2:0], ge};
                dden_reg[i+1] <= dden_reg[i];
                dneg_reg[i+1] <= dneg_reg[i];
            end
        end
    end

    always_comb begin
        ysum = ymul_reg + YP_W'(HALF_Q24);
        ym   = ysum[YP_W-1:FRAC_W];
        yml  = ym[FRAC_W-1:0];
        yhi  = EXP_W'(ym[YM_W-1:FRAC_W]);
        if (!yneg_reg) begin
            n_next = yhi;
            f_next = yml;
        end else if (yml == '0) begin
            n_next = EXP_W'(0) - yhi;
            f_next = '0;
        end else begin
            n_next = EXP_W'(0) - yhi - EXP_W'(1);
            f_next = FRAC_W'(0) - yml;
        end
        zsum   = zmul_reg + ZP_W'(HALF_Q24);
        shfull = SVP_EXP_BIAS - sn2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ymul_reg    <= YP_W'(dlow_reg[XQ_W]) * YP_W'(LOG2E_Q24);
            yneg_reg    <= dneg_reg[XQ_W];
            n_reg       <= n_next;
            f_reg       <= f_next;
            zmul_reg    <= ZP_W'(f_reg) * ZP_W'(LN2_Q24);
            zn_reg      <= n_reg;
            term_reg[0] <= TERM_ONE;
            tsum_reg[0] <= '0;
            tz_reg[0]   <= zsum[ZP_W-1:FRAC_W];
            tn_reg[0]   <= zn_reg;
        end
    end

    for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_taylor
        localparam logic [RCP_W-1:0] Recip =
            RCP_W'(((65'd1 << RCP_SH) + 65'(i)) / 65'(i + 1));
        logic [TV_W-1:0] v;
        logic [TQ_W-1:0] q;
        always_comb begin
            v = amul_reg[i][TV_W+FRAC_W-1:FRAC_W];
            q = TQ_W'(v) * TQ_W'(Recip);
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                amul_reg[i]   <= AP_W'(term_reg[i]) * AP_W'(tz_reg[i]);
                asum_reg[i]   <= tsum_reg[i] + SUM_W'(term_reg[i]);
                az_reg[i]     <= tz_reg[i];
                an_reg[i]     <= tn_reg[i];
                term_reg[i+1] <= TERM_W'(q[RCP_SH+TV_W-1:RCP_SH]);
                tsum_reg[i+1] <= asum_reg[i];
                tz_reg[i+1]   <= az_reg[i];
                tn_reg[i+1]   <= an_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sumf_reg <= tsum_reg[TAYLOR_TERMS] + SUM_W'(term_reg[TAYLOR_TERMS]);
            sn1_reg  <= tn_reg[TAYLOR_TERMS];
            s_reg    <= SP_W'(sumf_reg) * SP_W'(SVP0_DPA);
            sn2_reg  <= sn1_reg;
            svp_reg  <= SVP_W'(s_reg >> shfull[SH_W-1:0]);
        end
    end

    assign svp = svp_reg;

endmodule

[rtl/core/vapour_pressure_deficit.sv]
// Vapour pressure deficit from air temperature and humidity, fully pipelined.
// Depends on vpd_pkg and vpd_svp.
//
//  port group   dir  contents (low bit first)
//  s_t*         in   tdata: air_temperature[13:0], relative_humidity[23:14]
//  m_t*         out  tdata: deficit[16:0], zero pad; tuser: clamped
//  cfg_*        in   data: leaf_offset[10:0]
//
// One transfer in and one out per cycle while the output is not stalled; latency is
// set by the quotient divider and twelfth-order Taylor exp in each saturation pressure unit
// plus the reciprocal multiply that divides actual pressure by 1000. A stall
// at m_tready holds the whole pipeline. Reset clears valid bits and
// leaf_offset; cfg_ready is high.
module vapour_pressure_deficit import vpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // air_temperature, relative_humidity
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // deficit
    output logic              m_tuser,   // clamped
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [OFFS_W-1:0] cfg_data   // leaf_offset
);

    logic                adv;
    logic [OFFS_W-1:0]   leaf_offset_reg;
    logic [VLD_LEN-1:0]  vld_reg;
    logic [TEMP_W-1:0]   tair_reg;
    logic [TEMP_W-1:0]   tleaf_reg;
    logic [RH_W-1:0]     rh_reg [0:SVP_LAT];
    logic [SVP_W-1:0]    svp_air;
    logic [SVP_W-1:0]    svp_leaf;
    logic [ACT_P_W-1:0]  prod;

    logic [ACT_X_W-1:0]   ax_reg;
    logic [SVP_W-1:0]     aleaf_reg [0:ACT_LAT-1];
    logic [ACT_PPL_W-1:0] pp_ll_reg;
    logic [ACT_PPL_W-1:0] pp_lh_reg;
    logic [ACT_PPH_W-1:0] pp_hl_reg;
    logic [ACT_PPH_W-1:0] pp_hh_reg;
    logic [ACT_MID_W-1:0] mid_reg;
    logic [ACT_TOT_W-1:0] ppc_reg;
    logic [ACT_TOT_W-1:0] tot;
    logic [ACT_W-1:0]     act_reg;

    logic                 clamp;
    logic [SVP_W-1:0]     diff;
    logic [DEF_SUM_W-1:0] rsum;
    logic [DEF_PRE_W-1:0] dw_reg;
    logic                 dclamp_reg;
    logic [DEF_P_W-1:0]   emul_reg;
    logic                 eclamp_reg;
    logic [DEF_Q_W-1:0]   dq;
    logic [DEF_W-1:0]     deficit_reg;
    logic                 clamped_reg;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[VLD_LEN-1];
    assign m_tdata   = {(24 - DEF_W)'(0), deficit_reg};
    assign m_tuser   = clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaf_offset_reg <= '0;
            vld_reg         <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                leaf_offset_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[VLD_LEN-2:0], s_tvalid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tair_reg  <= TEMP_W'(signed'(s_tdata[TEMP_IN_W-1:0]));
            tleaf_reg <= TEMP_W'(signed'(s_tdata[TEMP_IN_W-1:0]))
                       + TEMP_W'(signed'(leaf_offset_reg));
            rh_reg[0] <= s_tdata[TEMP_IN_W+RH_W-1:TEMP_IN_W];
            for (int i = 1; i <= SVP_LAT; i++) begin
                rh_reg[i] <= rh_reg[i-1];
            end
        end
    end

    vpd_svp u_svp_air (
        .aclk (aclk),
        .adv  (adv),
        .temp (tair_reg),
        .svp  (svp_air)
    );

    vpd_svp u_svp_leaf (
        .aclk (aclk),
        .adv  (adv),
        .temp (tleaf_reg),
        .svp  (svp_leaf)
    );

    assign prod = ACT_P_W'(svp_air) * ACT_P_W'(rh_reg[SVP_LAT]);

    // divide by 8, then by 125 through the reciprocal, split in partial products
    always_comb begin
        tot = ppc_reg + (ACT_TOT_W'(mid_reg) << ACT_LO_W);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg       <= prod[ACT_P_W-1:ACT_X_SH];
            aleaf_reg[0] <= svp_leaf;
            pp_ll_reg    <= ACT_PPL_W'(ax_reg[ACT_LO_W-1:0])
                          * ACT_PPL_W'(ACT_RCP[ACT_LO_W-1:0]);
            pp_lh_reg    <= ACT_PPL_W'(ax_reg[ACT_LO_W-1:0])
                          * ACT_PPL_W'(ACT_RCP[ACT_RCP_W-1:ACT_LO_W]);
            pp_hl_reg    <= ACT_PPH_W'(ax_reg[ACT_X_W-1:ACT_LO_W])
                          * ACT_PPH_W'(ACT_RCP[ACT_LO_W-1:0]);
            pp_hh_reg    <= ACT_PPH_W'(ax_reg[ACT_X_W-1:ACT_LO_W])
                          * ACT_PPH_W'(ACT_RCP[ACT_RCP_W-1:ACT_LO_W]);
            mid_reg      <= ACT_MID_W'(pp_lh_reg) + ACT_MID_W'(pp_hl_reg);
            ppc_reg      <= {pp_hh_reg, pp_ll_reg};
            act_reg      <= tot[ACT_RCP_SH+ACT_W-1:ACT_RCP_SH];
            for (int i = 1; i < ACT_LAT; i++) begin
                aleaf_reg[i] <= aleaf_reg[i-1];
            end
        end
    end

    always_comb begin
        clamp = aleaf_reg[ACT_LAT-1] < act_reg;
        diff  = aleaf_reg[ACT_LAT-1] - act_reg;
        rsum  = DEF_SUM_W'(diff) + ROUND_HALF_PA;
        dq    = emul_reg[DEF_P_W-1:DEF_SH];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dw_reg     <= rsum[DEF_SUM_W-1:DEF_PRE_SH];
            dclamp_reg <= clamp;
            emul_reg   <= DEF_P_W'(dw_reg) * DEF_P_W'(RECIP10);
            eclamp_reg <= dclamp_reg;
            if (eclamp_reg) begin
                deficit_reg <= '0;
                clamped_reg <= 1'b1;
            end else if (dq > DEFICIT_MAX) begin
                deficit_reg <= DEF_W'(DEFICIT_MAX);
                clamped_reg <= 1'b0;
            end else begin
                deficit_reg <= dq[DEF_W-1:0];
                clamped_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_clamp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[DEF_W-1:0] == '0)
        else $error("clamped result carries a nonzero deficit");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while waiting for a transfer");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transfer not tracked in the pipeline");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("valid pattern moved during a stall");
`endif

endmodule

[tb/tb_vapour_pressure_deficit.sv]
// Testbench for vapour_pressure_deficit: directed and random samples under
// several leaf offsets, checked against an in-bench fixed-point Magnus model.
// Depends on vpd_pkg and the vapour_pressure_deficit RTL.
module tb_vapour_pressure_deficit;
    import vpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [16:0] deficit;
        logic        clamped;
    } vpd_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [OFFS_W-1:0] cfg_data = '0;

    vpd_result_t       pending_results[$];
    logic signed [10:0] leaf_offset_mdl = '0;
    int                errors = 0;
    int                results_seen = 0;
    int                samples_sent = 0;
    int                offsets_used = 0;
    bit                no_idle = 1'b0;

    vapour_pressure_deficit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("vapour_pressure_deficit verification failed");
        $finish;
    end

    // Saturation pressure in decipascals, Q16; t in 0.01 degC
    function automatic logic [63:0] svp_dpa_q16(longint t);
        longint      num;
        logic [63:0] den, mag, xm, ym, f, z, term, sum, s;
        longint      y, n;
        num = 1727 * t;
        den = 64'(100 * (t + 23730));
        mag = (num < 0) ? 64'(-num) : 64'(num);
        xm = ((mag << 24) + den / 2) / den;
        ym = (xm * 64'd24204406 + 64'd8388608) >> 24;
        y = (num < 0) ? -longint'(ym) : longint'(ym);
        if (y >= 0) n = y >>> 24;
        else n = -((-y + 64'hFFFFFF) >>> 24);
        f = 64'(y - n * 16777216);
        z = (f * 64'd11629080 + 64'd8388608) >> 24;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * z) >> 24) / k;
            sum += term;
        end
        s = 64'd6108 * sum;
        if (n > 14) return s << 8;
        if (14 - n > 63) return '0;
        return s >> (14 - n);
    endfunction

    function automatic vpd_result_t deficit_of(logic [13:0] t_code, logic [9:0] rh);
        longint      t_air;
        logic [63:0] s_air, s_leaf, actual, d;
        vpd_result_t r;
        t_air = longint'($signed(t_code));
        s_air = svp_dpa_q16(t_air);
        s_leaf = svp_dpa_q16(t_air + longint'(leaf_offset_mdl));
        actual = (s_air * 64'(rh)) / 1000;
        if (s_leaf < actual) begin
            r.deficit = '0;
            r.clamped = 1'b1;
        end else begin
            d = (s_leaf - actual + 64'd327680) / 64'd655360;
            if (d > 64'd131071) d = 64'd131071;
            r.deficit = d[16:0];
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, deficit", m_tdata[16:0], -1);
            end else begin
                vpd_result_t want;
                want = pending_results.pop_front();
                if (m_tdata[16:0] !== want.deficit)
                    report_mismatch("deficit", m_tdata[16:0], want.deficit);
                if (m_tuser !== want.clamped)
                    report_mismatch("clamped", m_tuser, want.clamped);
                if (m_tdata[23:17] !== '0)
                    report_mismatch("tdata pad", m_tdata[23:17], 0);
                results_seen++;
            end
        end
    end

    // hold ready low for a random stall, then high until a transfer
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_sample(logic [13:0] t_code, logic [9:0] rh);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rh, t_code};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(deficit_of(t_code, rh));
        samples_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (VLD_LEN + 10) @(posedge aclk);
    endtask

    task automatic write_leaf_offset(logic [10:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        leaf_offset_mdl = value;
        offsets_used++;
    endtask

    task automatic test_directed();
        logic [13:0] temps[6] = '{14'h2000, 14'h1FFF, -14'sd4000, 14'd8000, 14'd0, 14'd2500};
        logic [9:0]  hums[5] = '{10'd0, 10'd1000, 10'd1023, 10'd500, 10'd1};
        foreach (temps[i]) send_sample(temps[i], hums[i % 5]);
        send_sample(14'd2000, 10'd1000);
        send_sample(14'd2000, 10'd0);
        send_sample(14'h3FFF, 10'h3FF);
        send_sample(14'd0, 10'h2AA);
        send_sample(14'h1555, 10'h155);
    endtask

    task automatic test_random(int count);
        logic [13:0] t_code;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) t_code = 14'($urandom);
            else t_code = 14'($signed($urandom_range(0, 12000)) - 4000);
            send_sample(t_code, ($urandom_range(0, 7) == 0) ? 10'($urandom)
                                                            : 10'($urandom_range(0, 1000)));
        end
    endtask

    task automatic test_no_idle_burst();
        no_idle = 1'b1;
        test_random(60);
        no_idle = 1'b0;
    endtask

    task automatic test_offsets();
        logic [10:0] offs[6] = '{11'd1000, -11'sd1000, 11'h400, 11'h3FF, 11'd150, 11'd0};
        foreach (offs[i]) begin
            write_leaf_offset(offs[i]);
            test_directed();
            test_random(150);
        end
        write_leaf_offset(11'($urandom));
        test_random(120);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(120);
        drain_pipeline();
        test_no_idle_burst();
        test_offsets();
        drain_pipeline();
        $display("sent %0d samples over %0d leaf offsets, checked %0d results",
                 samples_sent, offsets_used, results_seen);
        $display("covered temperature and humidity extremes, clamping and stalls");
        if (errors == 0) begin
            $display("vapour_pressure_deficit verification clean");
        end else begin
            $display("vapour_pressure_deficit verification failed");
        end
        $finish;
    end
endmodule
